// ===== sv/cor_pkg.sv =====
package cor_pkg;

	// Field widths of the request and pixel channels.
	localparam int IN_COORD_W  = 11;
	localparam int IN_RADIUS_W = 10;
	localparam int COLOR_W     = 24;
	localparam int PIX_W       = 13;

	// Command codes.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Number of symmetric points sent for each step.
	localparam int POINTS_PER_STEP = 8;
	localparam int PHASE_W         = $clog2(POINTS_PER_STEP);

endpackage

// ===== sv/cor_if.sv =====
// Request channel: one command with the circle description.
interface cor_req_if;
	logic                                valid;
	logic                                ready;
	logic                                command;
	logic [cor_pkg::IN_COORD_W-1:0]      center_x;
	logic [cor_pkg::IN_COORD_W-1:0]      center_y;
	logic [cor_pkg::IN_RADIUS_W-1:0]     radius;
	logic [cor_pkg::COLOR_W-1:0]         color;

	modport source (output valid, command, center_x, center_y, radius, color, input ready);
	modport sink   (input valid, command, center_x, center_y, radius, color, output ready);
	modport mon    (input valid, ready, command, center_x, center_y, radius, color);
endinterface

// Pixel channel: one outline point per transfer.
interface cor_pix_if;
	logic                                valid;
	logic                                ready;
	logic signed [cor_pkg::PIX_W-1:0]    pixel_x;
	logic signed [cor_pkg::PIX_W-1:0]    pixel_y;
	logic [cor_pkg::COLOR_W-1:0]         pixel_color;
	logic                                last_point;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last_point, input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_point, output ready);
	modport mon    (input valid, ready, pixel_x, pixel_y, pixel_color, last_point);
endinterface

// ===== sv/cor_front.sv =====
// Command decoder and octant walker. Each step of an active walk pushes one
// octant job (center, offsets, color, last flag) toward the point emitter.
module cor_front #(
	parameter int COORD_BITS  = 11,
	parameter int RADIUS_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	cor_req_if.sink                        req,
	output logic                           job_valid,
	input  logic                           job_ready,
	output logic [COORD_BITS-1:0]          job_cx,
	output logic [COORD_BITS-1:0]          job_cy,
	output logic signed [RADIUS_BITS+1:0]  job_x,
	output logic signed [RADIUS_BITS+1:0]  job_y,
	output logic [cor_pkg::COLOR_W-1:0]    job_color,
	output logic                           job_last
);

	localparam int OW = RADIUS_BITS + 2;
	localparam int DW = RADIUS_BITS + 6;

	logic [COORD_BITS-1:0]       center_col_q;
	logic [COORD_BITS-1:0]       center_row_q;
	logic signed [OW-1:0]        offset_x_q;
	logic signed [OW-1:0]        offset_y_q;
	logic signed [DW-1:0]        decision_q;
	logic [cor_pkg::COLOR_W-1:0] draw_color_q;
	logic                        active_q;

	logic                        accept;
	logic                        is_start;
	logic                        do_step;
	logic [RADIUS_BITS-1:0]      radius_r;
	logic signed [OW-1:0]        x_next;
	logic signed [OW-1:0]        y_next;
	logic signed [DW-1:0]        dec_next;
	logic signed [DW-1:0]        x_ext;
	logic signed [DW-1:0]        y_ext;
	logic                        done;

	assign req.ready = job_ready;
	assign accept    = req.valid && req.ready;
	assign is_start  = (req.command == cor_pkg::CMD_START);
	assign do_step   = accept && !is_start && active_q;
	assign radius_r  = RADIUS_BITS'(req.radius);

	// Next offsets and decision term of the walk.
	always_comb begin
		x_next = offset_x_q + OW'(1);
		if (decision_q > DW'(0)) begin
			y_next = offset_y_q - OW'(1);
		end else begin
			y_next = offset_y_q;
		end
		x_ext = DW'(x_next);
		y_ext = DW'(y_next);
		if (decision_q > DW'(0)) begin
			dec_next = decision_q + ((x_ext - y_ext) <<< 2) + DW'(10);
		end else begin
			dec_next = decision_q + (x_ext <<< 2) + DW'(6);
		end
		done = (y_next < x_next);
	end

	// Walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q <= '0;
			center_row_q <= '0;
			offset_x_q   <= '0;
			offset_y_q   <= '0;
			decision_q   <= '0;
			draw_color_q <= '0;
			active_q     <= 1'b0;
		end else if (accept && is_start) begin
			center_col_q <= COORD_BITS'(req.center_x);
			center_row_q <= COORD_BITS'(req.center_y);
			draw_color_q <= req.color;
			offset_x_q   <= '0;
			offset_y_q   <= signed'(OW'(radius_r));
			decision_q   <= DW'(3) - (signed'(DW'(radius_r)) <<< 1);
			active_q     <= 1'b1;
		end else if (do_step) begin
			offset_x_q <= x_next;
			offset_y_q <= y_next;
			decision_q <= dec_next;
			if (done) begin
				active_q <= 1'b0;
			end
		end
	end

	// Job toward the queue holds the offsets from before the update.
	assign job_valid = do_step;
	assign job_cx    = center_col_q;
	assign job_cy    = center_row_q;
	assign job_x     = offset_x_q;
	assign job_y     = offset_y_q;
	assign job_color = draw_color_q;
	assign job_last  = done;

endmodule

// ===== sv/cor_queue.sv =====
// Small first-in first-out buffer for octant jobs.
module cor_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== sv/cor_back.sv =====
// Point emitter: turns one octant job into its eight symmetric points, one
// per cycle while pix is ready.
module cor_back #(
	parameter int COORD_BITS  = 11,
	parameter int RADIUS_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           job_valid,
	output logic                           job_ready,
	input  logic [COORD_BITS-1:0]          job_cx,
	input  logic [COORD_BITS-1:0]          job_cy,
	input  logic signed [RADIUS_BITS+1:0]  job_x,
	input  logic signed [RADIUS_BITS+1:0]  job_y,
	input  logic [cor_pkg::COLOR_W-1:0]    job_color,
	input  logic                           job_last,
	cor_pix_if.source                      pix
);

	localparam int OW  = RADIUS_BITS + 2;
	localparam int MW  = ((COORD_BITS + 1) > OW) ? (COORD_BITS + 1) : OW;
	localparam int AW0 = MW + 1;
	localparam int AW  = (AW0 > cor_pkg::PIX_W) ? AW0 : cor_pkg::PIX_W;
	localparam int PHW = cor_pkg::PHASE_W;

	logic [COORD_BITS-1:0]       cx_q;
	logic [COORD_BITS-1:0]       cy_q;
	logic signed [OW-1:0]        x_q;
	logic signed [OW-1:0]        y_q;
	logic [cor_pkg::COLOR_W-1:0] color_q;
	logic                        last_q;
	logic [PHW-1:0]              phase_q;
	logic                        busy_q;

	logic                        final_phase;
	logic                        load;
	logic signed [AW-1:0]        dx;
	logic signed [AW-1:0]        dy;
	logic signed [AW-1:0]        sum_x;
	logic signed [AW-1:0]        sum_y;

	assign final_phase = (phase_q == PHW'(cor_pkg::POINTS_PER_STEP - 1));
	assign job_ready   = !busy_q || (final_phase && pix.ready);
	assign load        = job_valid && job_ready;

	// Job register and phase counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= '0;
		end else if (load) begin
			busy_q  <= 1'b1;
			phase_q <= '0;
		end else if (busy_q && pix.ready) begin
			phase_q <= phase_q + PHW'(1);
			if (final_phase) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cx_q    <= job_cx;
			cy_q    <= job_cy;
			x_q     <= job_x;
			y_q     <= job_y;
			color_q <= job_color;
			last_q  <= job_last;
		end
	end

	// Phase bit 2 swaps the offsets, bit 0 negates the column term and
	// bit 1 negates the row term.
	always_comb begin
		if (phase_q[2]) begin
			dx = AW'(y_q);
			dy = AW'(x_q);
		end else begin
			dx = AW'(x_q);
			dy = AW'(y_q);
		end
		if (phase_q[0]) begin
			dx = -dx;
		end
		if (phase_q[1]) begin
			dy = -dy;
		end
		sum_x = signed'(AW'(cx_q)) + dx;
		sum_y = signed'(AW'(cy_q)) + dy;
	end

	assign pix.valid       = busy_q;
	assign pix.pixel_x     = sum_x[cor_pkg::PIX_W-1:0];
	assign pix.pixel_y     = sum_y[cor_pkg::PIX_W-1:0];
	assign pix.pixel_color = color_q;
	assign pix.last_point  = busy_q && last_q && final_phase;

endmodule

// ===== sv/circle_outline_rasterizer.sv =====
// Channel  Role    Payload
// req      sink    command, center_x, center_y, radius, color
// pix      source  pixel_x, pixel_y, pixel_color, last_point
//
// A step of an active walk yields eight points, one per cycle while pix is
// ready, paced by the emitter's phase counter; new steps are taken only while
// the queue has room. Start commands and idle steps leave no points.
// A two-entry job queue lets the walker run up to two steps ahead of the emitter.
// Reset is asynchronous and clears the walk, the queue and the emitter.
// A stall on pix holds the current point; req stalls once the queue is full.
module circle_outline_rasterizer #(
	parameter int COORD_BITS  = 11,
	parameter int RADIUS_BITS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	cor_req_if.sink   req,
	cor_pix_if.source pix
);

	localparam int OW = RADIUS_BITS + 2;
	localparam int JW = 2 * COORD_BITS + 2 * OW + cor_pkg::COLOR_W + 1;

	logic                        f_valid;
	logic                        f_ready;
	logic [COORD_BITS-1:0]       f_cx;
	logic [COORD_BITS-1:0]       f_cy;
	logic signed [OW-1:0]        f_x;
	logic signed [OW-1:0]        f_y;
	logic [cor_pkg::COLOR_W-1:0] f_color;
	logic                        f_last;

	logic                        b_valid;
	logic                        b_ready;
	logic [JW-1:0]               b_data;

	// Walker.
	cor_front #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job_cx    (f_cx),
		.job_cy    (f_cy),
		.job_x     (f_x),
		.job_y     (f_y),
		.job_color (f_color),
		.job_last  (f_last)
	);

	// Job queue.
	cor_queue #(
		.WIDTH (JW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_cx, f_cy, f_x, f_y, f_color, f_last}),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	// Point emitter.
	cor_back #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job_cx    (b_data[JW-1 -: COORD_BITS]),
		.job_cy    (b_data[JW-COORD_BITS-1 -: COORD_BITS]),
		.job_x     (signed'(b_data[JW-2*COORD_BITS-1 -: OW])),
		.job_y     (signed'(b_data[JW-2*COORD_BITS-OW-1 -: OW])),
		.job_color (b_data[cor_pkg::COLOR_W:1]),
		.job_last  (b_data[0]),
		.pix       (pix)
	);

endmodule

// ===== sv/cor_checker.sv =====
// Port-level checks on the request and pixel channels.
module cor_checker (
	input logic       clk,
	input logic       arst_n,
	cor_req_if.sink   req,
	cor_pix_if.source pix
);

	logic [cor_pkg::PHASE_W-1:0] count_q;
	logic [cor_pkg::COLOR_W-1:0] color_q;
	logic                        in_group;

	// Position of the next point within its group of eight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (pix.valid && pix.ready) begin
			count_q <= count_q + cor_pkg::PHASE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			color_q <= pix.pixel_color;
		end
	end

	assign in_group = (count_q != '0);

	// A waiting request keeps its fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && !req.ready |=> req.valid && $stable(req.command)
			&& $stable(req.center_x) && $stable(req.center_y)
			&& $stable(req.radius) && $stable(req.color))
	else $error("request changed while waiting");

	// A stalled point holds its coordinates and last flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && !pix.ready |=> pix.valid && $stable(pix.pixel_x)
			&& $stable(pix.pixel_y) && $stable(pix.last_point))
	else $error("pixel changed while stalled");

	// The last flag sits only on the eighth point of a step.
	assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.last_point |->
			count_q == cor_pkg::PHASE_W'(cor_pkg::POINTS_PER_STEP - 1))
	else $error("last point flag off the eighth point");

	// Points of one step share one color.
	assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && in_group |-> pix.pixel_color == color_q)
	else $error("color changed within a step");

endmodule

bind circle_outline_rasterizer cor_checker u_cor_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.pix    (pix)
);
